[rtl/fefh_pkg.sv]
// shared constants and command/status types of the edge-hold fir filter
package fefh_pkg;

  localparam int MAX_TAPS = 32;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int CFG_W    = 6;
  localparam int SLOT_W   = 5;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int OUT_W    = 16;
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + TAP_W;

  // word kinds on the input channel
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic             start;
    logic             coef_we;
    logic             mac_en;
    logic [TAP_W-1:0] tap_idx;
    logic [TAP_W-1:0] hist_idx;
    logic             out_load;
  } fefh_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_full;
  } fefh_sts_t;

endpackage

[rtl/fefh_dp.sv]
// datapath: history line, tap table, shared multiply-accumulate and output register
module fefh_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fefh_pkg::fefh_cmd_t                cmd_i,
  output fefh_pkg::fefh_sts_t                sts_o,
  input  logic signed [fefh_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                               signal_start_i,
  input  logic [fefh_pkg::SLOT_W-1:0]        coef_slot_i,
  input  logic signed [fefh_pkg::COEF_W-1:0] coef_word_i,
  input  logic                               out_stall_i,
  output logic                               out_valid_o,
  output logic signed [fefh_pkg::OUT_W-1:0]  filtered_value_o,
  output logic                               clipped_o
);
  import fefh_pkg::*;

  logic signed [SAMPLE_W-1:0] hist_q [MAX_TAPS];
  logic signed [COEF_W-1:0]   tap_q  [MAX_TAPS];
  logic signed [PROD_W-1:0]   prod_q;
  logic                       prod_vld_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic                       out_vld_q;
  logic signed [OUT_W-1:0]    out_val_q;
  logic                       out_clip_q;

  logic signed [PROD_W-1:0]   prod_d;
  logic                       ovf;
  logic signed [OUT_W-1:0]    sat_val;

  assign prod_d = tap_q[cmd_i.tap_idx] * hist_q[cmd_i.hist_idx];

  // floor shift is dropping the fraction bits; overflow when the bits above
  // the 16-bit window disagree with its sign bit
  assign ovf = !((&acc_q[ACC_W-1:FRAC_W+OUT_W-1]) || !(|acc_q[ACC_W-1:FRAC_W+OUT_W-1]));
  always_comb begin
    if (ovf) begin
      sat_val = acc_q[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      sat_val = acc_q[FRAC_W+OUT_W-1:FRAC_W];
    end
  end

  // history and tap table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        hist_q[i] <= '0;
        tap_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.start) begin
        if (signal_start_i) begin
          for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= sample_value_i;
        end else begin
          for (int i = MAX_TAPS - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
          hist_q[0] <= sample_value_i;
        end
      end
      if (cmd_i.coef_we && (int'(coef_slot_i) < MAX_TAPS)) begin
        tap_q[TAP_W'(coef_slot_i)] <= coef_word_i;
      end
    end
  end

  // multiply then accumulate, one register between
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= cmd_i.mac_en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_val_q  <= sat_val;
      out_clip_q <= ovf;
    end
  end

  assign sts_o.out_full  = out_vld_q;
  assign out_valid_o      = out_vld_q;
  assign filtered_value_o = out_val_q;
  assign clipped_o        = out_clip_q;

  a_start_no_pending_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start |-> !prod_vld_q)
    else $error("new word started while a product was still in flight");

  a_mac_feeds_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_en |=> prod_vld_q)
    else $error("issued tap product never reached the accumulator");

  a_no_load_during_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!prod_vld_q && !cmd_i.mac_en))
    else $error("result loaded before accumulation finished");

endmodule

[rtl/fefh_ctrl.sv]
// controller: word acceptance, tap sequencing and result handoff
module fefh_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          kind_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [fefh_pkg::CFG_W-1:0]    cfg_tap_count_i,
  input  logic                          out_stall_i,
  input  fefh_pkg::fefh_sts_t           sts_i,
  output fefh_pkg::fefh_cmd_t           cmd_o
);
  import fefh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [TAP_W-1:0] k_q, k_d;
  logic [TAP_W-1:0] nm1_q, nm1_d;
  logic             in_acc;
  logic             can_load;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign can_load = !sts_i.out_full || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    nm1_d   = nm1_q;
    cmd_o   = '0;
    cmd_o.tap_idx  = k_q;
    cmd_o.hist_idx = nm1_q - k_q;

    // tap count zero acts as one tap, above the table size it saturates
    if (cfg_valid_i && cfg_ready_i) begin
      if (cfg_tap_count_i == '0) begin
        nm1_d = '0;
      end else if (int'(cfg_tap_count_i) > MAX_TAPS) begin
        nm1_d = TAP_W'(MAX_TAPS - 1);
      end else begin
        nm1_d = TAP_W'(cfg_tap_count_i - CFG_W'(1));
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (kind_i == KIND_COEF) begin
            cmd_o.coef_we = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            k_d         = '0;
            state_d     = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd_o.mac_en = 1'b1;
        if (k_q == nm1_q) begin
          state_d = S_DRAIN;
        end else begin
          k_d = k_q + TAP_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
      nm1_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      nm1_q   <= nm1_d;
    end
  end

  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (k_q <= nm1_q))
    else $error("tap counter ran past the tap count");

  a_sample_starts_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && kind_i == KIND_SAMPLE) |=> (state_q == S_MAC && k_q == '0))
    else $error("accepted sample did not start the tap walk");

  a_drain_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (state_q == S_DONE))
    else $error("drain cycle not followed by result handoff");

endmodule

[rtl/fir_filter_edge_hold_top.sv]
// top level of the edge-hold direct-form fir filter
//
// input channel: in_valid_i / in_stall_o carry one word per handshake, either
// a sample word (kind_i low) or a coefficient word (kind_i high) that writes
// coef_word_i into tap coef_slot_i. a sample word with signal_start_i high
// first fills the whole history with itself
// output channel: out_valid_o / out_stall_i carry one result word per sample
// word, none per coefficient word
// config channel: cfg_valid_i / cfg_ready_o write the tap count, which the user
// must change only while the filter is idle; the block itself does not enforce it
// sequencing: a sample word with L taps in use walks them through the single
// shared multiplier, one tap per cycle, then passes a drain state and a done
// state that loads the result once the output register is free; the next word
// is accepted only after the result is loaded. a coefficient word is written
// straight into the tap table and leaves the filter idle for the next word
// reset: history, tap table cleared, tap count one, both channels empty
// a stalled receiver holds the result; a finished next result waits in the
// accumulator until the output register frees up
module fir_filter_edge_hold_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input words
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               kind_i,
  input  logic signed [fefh_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                               signal_start_i,
  input  logic [fefh_pkg::SLOT_W-1:0]        coef_slot_i,
  input  logic signed [fefh_pkg::COEF_W-1:0] coef_word_i,
  // tap count register
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fefh_pkg::CFG_W-1:0]         cfg_tap_count_i,
  // result words
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [fefh_pkg::OUT_W-1:0]  filtered_value_o,
  output logic                               clipped_o
);
  import fefh_pkg::*;

  fefh_cmd_t cmd;
  fefh_sts_t sts;

  // the register write is always taken; the user must issue it only while idle, the block does not enforce this
  assign cfg_ready_o = 1'b1;

  fefh_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .kind_i          (kind_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_tap_count_i (cfg_tap_count_i),
    .out_stall_i     (out_stall_i),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  fefh_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .sample_value_i   (sample_value_i),
    .signal_start_i   (signal_start_i),
    .coef_slot_i      (coef_slot_i),
    .coef_word_i      (coef_word_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .filtered_value_o (filtered_value_o),
    .clipped_o        (clipped_o)
  );

  // a held result must never be overwritten by the next one
  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !cmd.out_load)
    else $error("result overwritten while the receiver stalls");

endmodule

[sim/fefh_result_checker.sv]
// result checker for the edge-hold fir filter: predicts each result word and compares it
`timescale 1ns / 1ps

module fefh_result_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  logic                                 kind_i,
  input  logic signed [fefh_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic                                 signal_start_i,
  input  logic [fefh_pkg::SLOT_W-1:0]          coef_slot_i,
  input  logic signed [fefh_pkg::COEF_W-1:0]   coef_word_i,
  input  logic                                 cfg_valid_i,
  input  logic                                 cfg_ready_i,
  input  logic [fefh_pkg::CFG_W-1:0]           cfg_tap_count_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  logic signed [fefh_pkg::OUT_W-1:0]    filtered_value_i,
  input  logic                                 clipped_i,
  output int                                   mismatch_count_o,
  output int                                   pending_count_o
);
  import fefh_pkg::*;

  localparam longint OUT_MAX = longint'(2 ** (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -longint'(2 ** (OUT_W - 1));

  typedef struct packed {
    logic [OUT_W-1:0] value;
    logic             clipped;
  } filter_word_t;

  logic signed [SAMPLE_W-1:0] sample_history [MAX_TAPS];
  logic signed [COEF_W-1:0]   coef_table [MAX_TAPS];
  logic [CFG_W-1:0]           tap_count;
  filter_word_t               expected_words [$];

  // shift in one sample (flood the history on a signal start), then run the taps
  task automatic filter_sample(input logic signed [SAMPLE_W-1:0] x, input logic start,
                               output filter_word_t res);
    longint acc;
    longint y;
    int     n;
    int     k;
    if (start) begin
      for (k = 0; k < MAX_TAPS; k++) sample_history[k] = x;
    end else begin
      for (k = MAX_TAPS - 1; k > 0; k--) sample_history[k] = sample_history[k-1];
      sample_history[0] = x;
    end
    // zero taps act as one, anything above the table size as the full table
    if (tap_count == 0) n = 1;
    else if (int'(tap_count) > MAX_TAPS) n = MAX_TAPS;
    else n = int'(tap_count);
    // last used tap weights the newest sample
    acc = 0;
    for (k = 0; k < n; k++)
      acc += longint'(coef_table[k]) * longint'(sample_history[n-1-k]);
    y = acc >>> FRAC_W;
    res.clipped = 1'b0;
    if (y > OUT_MAX) begin
      y = OUT_MAX;
      res.clipped = 1'b1;
    end else if (y < OUT_MIN) begin
      y = OUT_MIN;
      res.clipped = 1'b1;
    end
    res.value = y[OUT_W-1:0];
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    filter_word_t want;
    filter_word_t fresh;
    if (!rst_ni) begin
      for (int k = 0; k < MAX_TAPS; k++) begin
        sample_history[k] = '0;
        coef_table[k]     = '0;
      end
      tap_count = CFG_W'(1);
      expected_words.delete();
      mismatch_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("filtered_value: expected no word, actual %0d", filtered_value_i);
          mismatch_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (filtered_value_i !== want.value) begin
            $error("filtered_value: expected %0d, actual %0d",
                   $signed(want.value), filtered_value_i);
            mismatch_count_o++;
          end
          if (clipped_i !== want.clipped) begin
            $error("clipped: expected %0d, actual %0d", want.clipped, clipped_i);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) tap_count = cfg_tap_count_i;
      if (in_valid_i && !in_stall_i) begin
        if (kind_i == KIND_COEF) begin
          coef_table[coef_slot_i] = coef_word_i;
        end else begin
          filter_sample(sample_value_i, signal_start_i, fresh);
          expected_words.push_back(fresh);
        end
      end
    end
    pending_count_o = expected_words.size();
  end

endmodule

[sim/tb_fir_filter_edge_hold_top.sv]
// testbench top for the edge-hold fir filter: stimulus, stalls and the verdict
`timescale 1ns / 1ps

module tb_fir_filter_edge_hold_top;
  import fefh_pkg::*;

  localparam int PHASES          = 14;
  localparam int WORDS_PER_PHASE = 118;
  // long receiver hold-off, long enough to back up the block behind a held result
  localparam int HOLD_OFF_CYCLES = 400;
  // coefficient words give no result, so this wait after the last result
  // makes sure the block is idle
  localparam int SETTLE_CYCLES   = 48;
  localparam int CYCLE_LIMIT     = 600000;

  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_stall;
  logic                kind           = KIND_SAMPLE;
  logic [SAMPLE_W-1:0] sample_value   = '0;
  logic                signal_start   = 1'b0;
  logic [SLOT_W-1:0]   coef_slot      = '0;
  logic [COEF_W-1:0]   coef_word      = '0;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [CFG_W-1:0]    cfg_tap_count  = '0;
  logic                out_valid;
  logic                out_stall      = 1'b0;
  logic [OUT_W-1:0]    filtered_value;
  logic                clipped;

  int                  mismatch_count;
  int                  pending_count;
  int unsigned         cycle_count    = 0;
  // no idling on either side while set
  logic                quiet          = 1'b0;
  // asks the receiver for one long hold-off
  logic                hold_off_req   = 1'b0;

  always #1 clk = ~clk;

  fir_filter_edge_hold_top dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .kind_i           (kind),
    .sample_value_i   (sample_value),
    .signal_start_i   (signal_start),
    .coef_slot_i      (coef_slot),
    .coef_word_i      (coef_word),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_tap_count_i  (cfg_tap_count),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_value_o (filtered_value),
    .clipped_o        (clipped)
  );

  fefh_result_checker result_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .kind_i           (kind),
    .sample_value_i   (sample_value),
    .signal_start_i   (signal_start),
    .coef_slot_i      (coef_slot),
    .coef_word_i      (coef_word),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_tap_count_i  (cfg_tap_count),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_value_i (filtered_value),
    .clipped_i        (clipped),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fir_filter_edge_hold_top test failed");
      $finish;
    end
  end

  // receiver side: short random stall bursts, one long hold-off on request,
  // nothing while quiet
  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        stall_left = HOLD_OFF_CYCLES - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // offer one word, maybe after a short gap, and return at the edge that takes it;
  // valid stays high so back-to-back words need no extra edge
  task automatic send_word(input logic k, input logic [SAMPLE_W-1:0] x, input logic st,
                           input logic [SLOT_W-1:0] slot, input logic [COEF_W-1:0] c);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    sample_value <= x;
    signal_start <= st;
    coef_slot    <= slot;
    coef_word    <= c;
    do @(posedge clk); while (in_stall);
  endtask

  // unused fields of a word still get random bits
  task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic st);
    send_word(KIND_SAMPLE, x, st, SLOT_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_coef(input logic [SLOT_W-1:0] slot, input logic [COEF_W-1:0] c);
    send_word(KIND_COEF, SAMPLE_W'($urandom), 1'($urandom), slot, c);
  endtask

  // stop offering and wait until every result is in and the datapath is done
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      while (pending_count != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_count != 0);
  endtask

  // tap count is only written while the filter is idle
  task automatic write_tap_count(input logic [CFG_W-1:0] taps);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_tap_count <= taps;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // q1.15 value: the two extremes, small values around zero, or anything
  function automatic logic [15:0] pick_q15();
    case ($urandom_range(0, 5))
      0:       pick_q15 = 16'h7fff;
      1:       pick_q15 = 16'h8000;
      2:       pick_q15 = 16'($urandom_range(0, 512) - 256);
      default: pick_q15 = 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int               phase;
    int               i;
    int               roll;
    int               coef_words;
    logic [CFG_W-1:0] taps_setting;
    logic             loud;
    logic             loud_sign;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // no signal start since reset: history reads zero, tap table is zero
    send_sample(16'h7fff, 1'b0);
    // one tap at full scale against the most negative sample
    send_coef(5'd0, 16'h7fff);
    send_sample(16'h8000, 1'b0);
    // tap count zero behaves as one tap
    write_tap_count(6'd0);
    send_sample(16'h8000, 1'b1);
    // three most negative taps at the top of the table
    send_coef(5'd31, 16'h8000);
    send_coef(5'd30, 16'h8000);
    send_coef(5'd29, 16'h8000);
    // all-ones tap count saturates to the full table
    write_tap_count(6'h3f);
    send_sample(16'h8000, 1'b1);   // positive overflow, clipped
    send_sample(16'h7fff, 1'b0);   // newest sample meets the last tap
    send_sample(16'h7fff, 1'b1);   // negative overflow, clipped
    // just above the table size also saturates
    write_tap_count(6'd33);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b0);
    write_tap_count(6'd32);
    send_sample(16'h0000, 1'b1);
    // two taps: check which tap weights the newest sample
    write_tap_count(6'd2);
    send_coef(5'd1, 16'h4000);
    send_sample(16'h7fff, 1'b1);
    send_sample(16'h8000, 1'b0);
    // upper taps stay in the table while only one is used
    write_tap_count(6'd1);
    send_sample(16'h1234, 1'b0);

    // ---- random part ----
    for (phase = 0; phase < PHASES; phase++) begin
      // extremes of the tap count first, then anything the register holds
      case (phase)
        0:       taps_setting = 6'd32;
        1:       taps_setting = 6'd0;
        2:       taps_setting = 6'h3f;
        3:       taps_setting = 6'd1;
        4:       taps_setting = 6'd33;
        default: taps_setting = CFG_W'($urandom_range(0, 63));
      endcase
      write_tap_count(taps_setting);
      // some phases run without any idling, the last one always does
      quiet = (phase % 5 == 3) || (phase == PHASES - 1);
      // receiver backs up the block while the sender keeps offering words
      if (phase == 2) hold_off_req = 1'b1;
      // loud phases push the accumulator into saturation
      loud      = ($urandom_range(0, 3) == 0);
      loud_sign = 1'($urandom);

      coef_words = $urandom_range(2, 12);
      for (i = 0; i < coef_words; i++)
        send_coef(SLOT_W'($urandom), loud ? (loud_sign ? 16'h8000 : 16'h7fff) : pick_q15());

      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        roll = $urandom_range(0, 99);
        if (i == 0 || roll < 4)
          send_sample(loud ? ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff) : pick_q15(), 1'b1);
        else if (roll < 14)
          send_coef(SLOT_W'($urandom), pick_q15());   // retune mid-signal
        else
          send_sample(loud ? ($urandom_range(0, 1) ? 16'h8000 : 16'h7fff) : pick_q15(), 1'b0);
        // sender pauses until every result is back, then the signal goes on
        if (phase == 4 && i == WORDS_PER_PHASE / 2) wait_drained();
      end
    end

    wait_drained();
    if (mismatch_count == 0 && pending_count == 0)
      $display("fir_filter_edge_hold_top test passed");
    else
      $display("fir_filter_edge_hold_top test failed");
    $finish;
  end

endmodule
